// ===== sv/pid_heater_control_top_macros.svh =====
// ---------------------------------------------------------------------------
// PID heater control assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PID_HEATER_CONTROL_TOP_MACROS_SVH
`define PID_HEATER_CONTROL_TOP_MACROS_SVH

// Same-cycle implication.
`define PHC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pid heater control: assertion failed");

// Next-cycle implication.
`define PHC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pid heater control: assertion failed");

`endif

// ===== sv/phc_pkg.sv =====
// ---------------------------------------------------------------------------
// PID heater control package
// Fixed widths, constants, register indexes and shared status types.
// ---------------------------------------------------------------------------
package phc_pkg;

    localparam int TEMP_W    = 12;
    localparam int GAIN_W    = 16;
    localparam int MS_W      = 16;
    localparam int DUTY_W    = 8;
    localparam int FRAC_BITS = 12;

    // Iterative multiplier: 28-bit multiplicand, 16-bit multiplier.
    localparam int MUL_A_W   = 28;
    localparam int MUL_B_W   = 16;
    localparam int PROD_W    = 44;
    localparam int MUL_STEPS = 16;
    localparam int MUL_CNT_W = 4;

    // Restoring divider: 44-bit dividend, 16-bit divisor.
    localparam int DIV_N_W   = 44;
    localparam int DIV_D_W   = 16;
    localparam int DIV_STEPS = 44;
    localparam int DIV_CNT_W = 6;

    // Magnitudes of the integral increment and the derivative term.
    localparam int DI_W  = 35;
    localparam int D_W   = 38;
    localparam int SUM_W = 53;

    localparam logic [GAIN_W-1:0]       MS_PER_S  = 16'd1000;
    localparam logic [DUTY_W-1:0]       DUTY_MAX  = 8'd255;
    localparam logic signed [SUM_W-1:0] DUTY_FULL = 53'sd1044480;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } phc_stat_t;

endpackage

// ===== sv/pid_heater_control_top.sv =====
// ---------------------------------------------------------------------------
// PID heater control, derivative on measurement
// Each accepted transaction runs through the sequencer; the derivative states
// are skipped for the first sample or a zero elapsed time. Results come from the
// 16-step multiplier and the 44-step divider, used one after the other.
// A new transaction is taken only once the previous one has reached the output.
// Reset: asynchronous, all controller state and registers take their reset values.
// ---------------------------------------------------------------------------
module pid_heater_control_top
    import phc_pkg::*;
#(
    parameter int INTEGRATOR_BITS = 40
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [TEMP_W-1:0] temperature_sample,
    input  logic [MS_W-1:0]          elapsed_ms,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [DUTY_W-1:0]        drive,
    output logic                     heater_on,
    output logic signed [TEMP_W-1:0] measured_temp
);

`include "pid_heater_control_top_macros.svh"

    // Width of the exact integrator sum before saturation. The increment
    // magnitude is below 2^35, so at least 37 bits are needed.
    localparam int SW = ((INTEGRATOR_BITS > DI_W + 1) ? INTEGRATOR_BITS : DI_W + 1) + 1;
    // Width used to limit the integrator to +-2^50 for the output sum.
    localparam int CW = ((INTEGRATOR_BITS > SUM_W - 1) ? INTEGRATOR_BITS : SUM_W - 1) + 1;

    localparam logic signed [SW-1:0] I_MAX  = SW'((65'd1 << (INTEGRATOR_BITS - 1)) - 65'd1);
    localparam logic signed [SW-1:0] I_MIN  = ~I_MAX;
    localparam logic signed [CW-1:0] IC_POS = CW'(65'd1 << 50);
    localparam logic signed [CW-1:0] IC_NEG = -IC_POS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_IT,
        ST_DIV_I,
        ST_INTEG,
        ST_SUM_P,
        ST_MUL_D,
        ST_MUL_DK,
        ST_DIV_D,
        ST_SUM_D,
        ST_OUT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers. Write only while idle; the block does not check.
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0] setpoint_reg;
    logic [GAIN_W-1:0]        gain_p_reg;
    logic [GAIN_W-1:0]        gain_i_reg;
    logic [GAIN_W-1:0]        gain_d_reg;
    logic                     enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= 12'sd480;
            gain_p_reg   <= 16'd3840;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            enable_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SETPOINT: setpoint_reg <= cfg_data[TEMP_W-1:0];
                REG_GAIN_P:   gain_p_reg   <= cfg_data;
                REG_GAIN_I:   gain_i_reg   <= cfg_data;
                REG_GAIN_D:   gain_d_reg   <= cfg_data;
                REG_ENABLE:   enable_reg   <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and working registers. Every term is carried as a
    // magnitude with a separate sign, so that the divisions truncate
    // toward zero without any correction step.
    // ------------------------------------------------------------------
    state_t                           state_reg;
    logic                             launched_reg;
    logic signed [INTEGRATOR_BITS-1:0] integral_reg;
    logic signed [TEMP_W-1:0]         last_temp_reg;
    logic                             have_last_reg;
    logic signed [TEMP_W-1:0]         temp_reg;
    logic [MS_W-1:0]                  ms_reg;
    logic [TEMP_W-1:0]                e_mag_reg;
    logic                             e_neg_reg;
    logic [TEMP_W-1:0]                dt_mag_reg;
    logic                             dt_neg_reg;
    logic                             d_en_reg;
    logic [MUL_A_W-1:0]               p_mag_reg;
    logic [MUL_A_W-1:0]               a_reg;
    logic [PROD_W-1:0]                num_reg;
    logic [DI_W-1:0]                  di_mag_reg;
    logic [D_W-1:0]                   d_mag_reg;
    logic signed [SUM_W-1:0]          sum_reg;
    logic                             out_valid_reg;
    logic [DUTY_W-1:0]                drive_reg;
    logic                             heater_on_reg;
    logic signed [TEMP_W-1:0]         measured_reg;

    logic accept;
    logic out_free;
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Error and measurement difference, both 13-bit two's complement, taken
    // straight from the input port at the accepting edge.
    logic [TEMP_W:0]   err_full;
    logic [TEMP_W:0]   err_neg;
    logic [TEMP_W:0]   dt_full;
    logic [TEMP_W:0]   dt_neg;
    logic [TEMP_W-1:0] err_mag;
    logic [TEMP_W-1:0] dt_mag;

    always_comb
    begin
        err_full = {setpoint_reg[TEMP_W-1], setpoint_reg}
                 - {temperature_sample[TEMP_W-1], temperature_sample};
        err_neg  = -err_full;
        dt_full  = {last_temp_reg[TEMP_W-1], last_temp_reg}
                 - {temperature_sample[TEMP_W-1], temperature_sample};
        dt_neg   = -dt_full;
        err_mag  = err_full[TEMP_W] ? err_neg[TEMP_W-1:0] : err_full[TEMP_W-1:0];
        dt_mag   = dt_full[TEMP_W] ? dt_neg[TEMP_W-1:0] : dt_full[TEMP_W-1:0];
    end

    // ------------------------------------------------------------------
    // Shared arithmetic units and their operand selection.
    // ------------------------------------------------------------------
    logic               mul_start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    phc_stat_t          mul_stat;
    logic [PROD_W-1:0]  mul_product;

    logic               div_start;
    logic [DIV_D_W-1:0] div_den;
    phc_stat_t          div_stat;
    logic [DIV_N_W-1:0] div_quotient;

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        div_den = MS_PER_S;
        case (state_reg)
            ST_MUL_P:
            begin
                mul_a = {{(MUL_A_W - TEMP_W){1'b0}}, e_mag_reg};
                mul_b = gain_p_reg;
            end
            ST_MUL_I:
            begin
                mul_a = {{(MUL_A_W - TEMP_W){1'b0}}, e_mag_reg};
                mul_b = gain_i_reg;
            end
            ST_MUL_IT:
            begin
                mul_a = a_reg;
                mul_b = ms_reg;
            end
            ST_MUL_D:
            begin
                mul_a = {{(MUL_A_W - TEMP_W){1'b0}}, dt_mag_reg};
                mul_b = gain_d_reg;
            end
            ST_MUL_DK:
            begin
                mul_a = a_reg;
                mul_b = MS_PER_S;
            end
            ST_DIV_D:
            begin
                div_den = ms_reg;
            end
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                div_den = MS_PER_S;
            end
        endcase
        mul_start = !launched_reg
                  && (state_reg inside {ST_MUL_P, ST_MUL_I, ST_MUL_IT, ST_MUL_D, ST_MUL_DK});
        div_start = !launched_reg && (state_reg inside {ST_DIV_I, ST_DIV_D});
    end

    phc_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (mul_a),
        .multiplier   (mul_b),
        .stat         (mul_stat),
        .product      (mul_product)
    );

    phc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (div_den),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // ------------------------------------------------------------------
    // Integrator: the exact sum is formed one bit wider than either
    // operand and then saturated to the integrator's signed range.
    // ------------------------------------------------------------------
    logic signed [SW-1:0]              int_ext;
    logic signed [SW-1:0]              di_mag_ext;
    logic signed [SW-1:0]              di_ext;
    logic signed [SW-1:0]              int_sum;
    logic signed [SW-1:0]              int_sat;
    logic signed [INTEGRATOR_BITS-1:0] integral_next;

    always_comb
    begin
        int_ext    = {{(SW - INTEGRATOR_BITS){integral_reg[INTEGRATOR_BITS-1]}}, integral_reg};
        di_mag_ext = {{(SW - DI_W){1'b0}}, di_mag_reg};
        di_ext     = e_neg_reg ? -di_mag_ext : di_mag_ext;
        int_sum    = int_ext + di_ext;
        if (int_sum > I_MAX)
        begin
            int_sat = I_MAX;
        end
        else if (int_sum < I_MIN)
        begin
            int_sat = I_MIN;
        end
        else
        begin
            int_sat = int_sum;
        end
        integral_next = int_sat[INTEGRATOR_BITS-1:0];
    end

    // The integrator enters the output sum limited to +-2^50; this only
    // matters for the widest integrators and never changes the duty.
    logic signed [CW-1:0]    ic_ext;
    logic signed [CW-1:0]    ic_lim;
    logic signed [SUM_W-1:0] p_mag_ext;
    logic signed [SUM_W-1:0] p_term;
    logic signed [SUM_W-1:0] d_mag_ext;
    logic signed [SUM_W-1:0] d_term;
    logic [DUTY_W-1:0]       duty;

    always_comb
    begin
        ic_ext = {{(CW - INTEGRATOR_BITS){integral_reg[INTEGRATOR_BITS-1]}}, integral_reg};
        if (ic_ext > IC_POS)
        begin
            ic_lim = IC_POS;
        end
        else if (ic_ext < IC_NEG)
        begin
            ic_lim = IC_NEG;
        end
        else
        begin
            ic_lim = ic_ext;
        end
        p_mag_ext = {{(SUM_W - MUL_A_W){1'b0}}, p_mag_reg};
        p_term    = e_neg_reg ? -p_mag_ext : p_mag_ext;
        d_mag_ext = {{(SUM_W - D_W){1'b0}}, d_mag_reg};
        d_term    = dt_neg_reg ? -d_mag_ext : d_mag_ext;

        // Duty in whole units; the Q.12 fraction is dropped.
        if (!enable_reg)
        begin
            duty = '0;
        end
        else if (sum_reg >= DUTY_FULL)
        begin
            duty = DUTY_MAX;
        end
        else if (sum_reg[SUM_W-1] || (sum_reg == '0))
        begin
            duty = '0;
        end
        else
        begin
            duty = sum_reg[FRAC_BITS+DUTY_W-1:FRAC_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. Each arithmetic state launches its unit once and waits for
    // the done pulse, then captures the result. The derivative states are
    // skipped when there is no previous sample or no elapsed time, which
    // also keeps a zero divisor away from the divider.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            integral_reg  <= '0;
            last_temp_reg <= '0;
            have_last_reg <= 1'b0;
            temp_reg      <= '0;
            ms_reg        <= '0;
            e_mag_reg     <= '0;
            e_neg_reg     <= 1'b0;
            dt_mag_reg    <= '0;
            dt_neg_reg    <= 1'b0;
            d_en_reg      <= 1'b0;
            p_mag_reg     <= '0;
            a_reg         <= '0;
            num_reg       <= '0;
            di_mag_reg    <= '0;
            d_mag_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
            heater_on_reg <= 1'b0;
            measured_reg  <= '0;
        end
        else
        begin
            // In the output state the valid flag is handled there alone.
            if (out_valid_reg && out_ready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        temp_reg      <= temperature_sample;
                        ms_reg        <= elapsed_ms;
                        e_mag_reg     <= err_mag;
                        e_neg_reg     <= err_full[TEMP_W];
                        dt_mag_reg    <= dt_mag;
                        dt_neg_reg    <= dt_full[TEMP_W];
                        d_en_reg      <= have_last_reg && (elapsed_ms != '0);
                        d_mag_reg     <= '0;
                        last_temp_reg <= temperature_sample;
                        have_last_reg <= 1'b1;
                        launched_reg  <= 1'b0;
                        state_reg     <= ST_MUL_P;
                    end
                end
                ST_MUL_P, ST_MUL_I, ST_MUL_IT, ST_MUL_D, ST_MUL_DK:
                begin
                    if (!launched_reg)
                    begin
                        launched_reg <= 1'b1;
                    end
                    else if (mul_stat.done)
                    begin
                        launched_reg <= 1'b0;
                        case (state_reg)
                            ST_MUL_P:
                            begin
                                p_mag_reg <= mul_product[MUL_A_W-1:0];
                                state_reg <= ST_MUL_I;
                            end
                            ST_MUL_I:
                            begin
                                a_reg     <= mul_product[MUL_A_W-1:0];
                                state_reg <= ST_MUL_IT;
                            end
                            ST_MUL_IT:
                            begin
                                num_reg   <= mul_product;
                                state_reg <= ST_DIV_I;
                            end
                            ST_MUL_D:
                            begin
                                a_reg     <= mul_product[MUL_A_W-1:0];
                                state_reg <= ST_MUL_DK;
                            end
                            default:
                            begin
                                num_reg   <= mul_product;
                                state_reg <= ST_DIV_D;
                            end
                        endcase
                    end
                end
                ST_DIV_I, ST_DIV_D:
                begin
                    if (!launched_reg)
                    begin
                        launched_reg <= 1'b1;
                    end
                    else if (div_stat.done)
                    begin
                        launched_reg <= 1'b0;
                        if (state_reg == ST_DIV_I)
                        begin
                            di_mag_reg <= div_quotient[DI_W-1:0];
                            state_reg  <= ST_INTEG;
                        end
                        else
                        begin
                            d_mag_reg <= div_quotient[D_W-1:0];
                            state_reg <= ST_SUM_D;
                        end
                    end
                end
                ST_INTEG:
                begin
                    integral_reg <= integral_next;
                    state_reg    <= ST_SUM_P;
                end
                ST_SUM_P:
                begin
                    sum_reg   <= ic_lim[SUM_W-1:0] + p_term;
                    state_reg <= d_en_reg ? ST_MUL_D : ST_SUM_D;
                end
                ST_SUM_D:
                begin
                    sum_reg   <= sum_reg + d_term;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    // Holds here only while an earlier result is still waiting.
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        drive_reg     <= duty;
                        heater_on_reg <= duty != '0;
                        measured_reg  <= temp_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready      = state_reg == ST_IDLE;
    assign out_valid     = out_valid_reg;
    assign drive         = drive_reg;
    assign heater_on     = heater_on_reg;
    assign measured_temp = measured_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `PHC_ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready)
    `PHC_ASSERT_IMP(a_mul_idle, mul_start, !mul_stat.busy)
    `PHC_ASSERT_IMP(a_div_nonzero, div_start && (state_reg == ST_DIV_D), ms_reg != '0)
    `PHC_ASSERT_IMP(a_heater_match, out_valid, heater_on == (drive != '0))

endmodule

// ===== sv/phc_mul.sv =====
// ---------------------------------------------------------------------------
// PID heater control shift-add multiplier
// Unsigned product, one multiplier bit retired per clock cycle.
// ---------------------------------------------------------------------------
module phc_mul
    import phc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] multiplicand,
    input  logic [MUL_B_W-1:0] multiplier,
    output phc_stat_t          stat,
    output logic [PROD_W-1:0]  product
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]    acc_next;
    logic [PROD_W-1:0]    mcand_reg;
    logic [MUL_B_W-1:0]   mplier_reg;

    assign acc_next = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= {{(PROD_W - MUL_A_W){1'b0}}, multiplicand};
            mplier_reg <= multiplier;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[MUL_B_W-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule

// ===== sv/phc_div.sv =====
// ---------------------------------------------------------------------------
// PID heater control restoring divider
// Unsigned quotient, one quotient bit produced per clock cycle.
// ---------------------------------------------------------------------------
module phc_div
    import phc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output phc_stat_t          stat,
    output logic [DIV_N_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   rem_next;
    logic [DIV_N_W-1:0]   dq_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 fits;

    // The partial remainder stays below the divisor, so it never needs bit 16.
    always_comb
    begin
        trial    = {rem_reg, dq_reg[DIV_N_W-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= {dq_reg[DIV_N_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dq_reg;

endmodule

// ===== tb/sv/pid_heater_control_top_test.sv =====
// ---------------------------------------------------------------------------
// PID heater control testbench
// Sends temperature transactions through the controller under several
// register settings. An in-bench fixed-point controller predicts every duty
// result, and each result is compared field by field, in order, with it.
// ---------------------------------------------------------------------------
module pid_heater_control_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import phc_pkg::*;

    localparam int     INTEGRATOR_BITS = 40;
    localparam int     IDLE_MAX        = 13;       // longest random gap on either side
    localparam int     LONG_HOLD       = 1500;     // receiver hold-off, in cycles
    localparam int     HOLD_AFTER      = 60;       // results seen before the hold-off
    localparam int     SETTLE          = 200;      // a little over the worst latency
    localparam int     RUN_LIMIT       = 1000000;
    localparam int     PRINT_LIMIT     = 100;
    localparam int     PHASES          = 5;
    localparam int     PHASE_ITEMS     = 120;
    localparam int     WINDUP_ITEMS    = 70;
    localparam longint MS_IN_S         = 1000;
    localparam longint SUM_CAP         = longint'(1) << 50;
    localparam longint FULL_SCALE      = longint'(DUTY_MAX) << FRAC_BITS;

    // Register indexes that decode to nothing; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd7;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [MS_W-1:0]          ms;
    } sample_t;

    typedef struct {
        logic [DUTY_W-1:0]        drive;
        logic                     heater_on;
        logic signed [TEMP_W-1:0] temp;
    } duty_result_t;

    // Every input of the block holds a known value from time zero.
    logic                     clk                = 1'b0;
    logic                     rst_n              = 1'b0;
    logic                     cfg_write          = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index          = '0;
    logic [CFG_DATA_W-1:0]    cfg_data           = '0;
    logic                     in_valid           = 1'b0;
    logic signed [TEMP_W-1:0] temperature_sample = '0;
    logic [MS_W-1:0]          elapsed_ms         = '0;
    logic                     out_ready          = 1'b0;

    logic                     in_ready;
    logic                     out_valid;
    logic [DUTY_W-1:0]        drive;
    logic                     heater_on;
    logic signed [TEMP_W-1:0] measured_temp;

    // Shadow copy of the register file, updated as each write is issued.
    logic signed [TEMP_W-1:0] setpoint_r;
    logic [GAIN_W-1:0]        gain_p_r;
    logic [GAIN_W-1:0]        gain_i_r;
    logic [GAIN_W-1:0]        gain_d_r;
    logic                     enable_r;

    // Controller state as the predictor sees it.
    longint                   integ_acc;
    logic signed [TEMP_W-1:0] prev_temp;
    logic                     prev_valid;

    sample_t      sample_q[$];
    duty_result_t expected_duty_q[$];

    int in_issue_cnt   = 0;
    int in_accept_cnt  = 0;
    int out_accept_cnt = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int in_gap         = 0;
    int in_gap_max     = IDLE_MAX;
    int rx_wait        = 0;
    int rx_wait_max    = IDLE_MAX;
    int rx_seen        = 0;
    logic rx_hold      = 1'b0;

    pid_heater_control_top #(
        .INTEGRATOR_BITS (INTEGRATOR_BITS)
    ) u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .temperature_sample (temperature_sample),
        .elapsed_ms         (elapsed_ms),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .drive              (drive),
        .heater_on          (heater_on),
        .measured_temp      (measured_temp)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Prints are capped so that a badly broken design cannot flood the log;
    // every mismatch is still counted.
    task automatic report_mismatch(input string msg);
        error_count = error_count + 1;
        if (error_count <= PRINT_LIMIT)
            $display("ERROR: %s", msg);
    endtask

    // Works out the duty result of one accepted sample and advances the
    // predicted controller state. Every term is in duty units with FRAC_BITS
    // fraction bits, held in 64-bit signed arithmetic so that nothing wraps.
    task automatic predict_duty(input logic signed [TEMP_W-1:0] temp,
                                input logic [MS_W-1:0] ms);
        longint       err;
        longint       p_term;
        longint       di;
        longint       d_term;
        longint       capped;
        longint       total;
        longint       imax;
        longint       imin;
        duty_result_t res;

        imax   = (longint'(1) << (INTEGRATOR_BITS - 1)) - 1;
        imin   = -imax - 1;
        err    = longint'(setpoint_r) - longint'(temp);
        p_term = err * longint'(gain_p_r);
        di     = (err * longint'(gain_i_r) * longint'(ms)) / MS_IN_S;

        // The integrator saturates at its own signed width.
        if (di > 0 && integ_acc > imax - di)
            integ_acc = imax;
        else if (di < 0 && integ_acc < imin - di)
            integ_acc = imin;
        else
            integ_acc = integ_acc + di;

        // Derivative on measurement; none on the first sample or with no
        // elapsed time.
        d_term = 0;
        if (prev_valid && ms != 0)
            d_term = ((longint'(prev_temp) - longint'(temp)) * longint'(gain_d_r) * MS_IN_S)
                     / longint'(ms);
        prev_temp  = temp;
        prev_valid = 1'b1;

        capped = integ_acc;
        if (capped > SUM_CAP)
            capped = SUM_CAP;
        if (capped < -SUM_CAP)
            capped = -SUM_CAP;
        total = p_term + capped + d_term;

        res.drive = '0;
        if (enable_r)
        begin
            if (total >= FULL_SCALE)
                res.drive = DUTY_MAX;
            else if (total > 0)
                res.drive = DUTY_W'(total >>> FRAC_BITS);
        end
        res.heater_on = (res.drive != '0);
        res.temp      = temp;
        expected_duty_q.push_back(res);
    endtask

    // One register write, driven from one falling edge to the next.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_SETPOINT: setpoint_r = value[TEMP_W-1:0];
            REG_GAIN_P:   gain_p_r   = value[GAIN_W-1:0];
            REG_GAIN_I:   gain_i_r   = value[GAIN_W-1:0];
            REG_GAIN_D:   gain_d_r   = value[GAIN_W-1:0];
            REG_ENABLE:   enable_r   = value[0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic load_settings(input logic signed [TEMP_W-1:0] sp,
                                 input logic [GAIN_W-1:0] kp,
                                 input logic [GAIN_W-1:0] ki,
                                 input logic [GAIN_W-1:0] kd,
                                 input logic en);
        write_reg(REG_SETPOINT, CFG_DATA_W'(sp));
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_ENABLE, CFG_DATA_W'(en));
    endtask

    task automatic add_sample(input logic signed [TEMP_W-1:0] temp,
                              input logic [MS_W-1:0] ms);
        sample_t s;
        s.temp = temp;
        s.ms   = ms;
        sample_q.push_back(s);
    endtask

    // The block is idle once every queued transaction has been taken and every
    // expected result has come back. Each sample yields exactly one result, so
    // nothing can still be in flight at that point.
    task automatic wait_drained();
        while (sample_q.size() != 0 || in_accept_cnt != in_issue_cnt ||
               expected_duty_q.size() != 0)
            @(posedge clk);
    endtask

    // Gains are mostly modest so that the duty lands inside its range, with
    // zero, full scale and fully random values mixed in.
    function automatic logic [GAIN_W-1:0] pick_gain(input int usual_max);
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, usual_max));
        endcase
    endfunction

    // Sender: offers the next pending sample after a random gap. Once valid is
    // raised it stays up, with the payload held, until the transaction is
    // taken. The valid level is worked out first and assigned once per edge.
    always @(negedge clk)
    begin : sender
        sample_t item;
        logic    offer;
        offer = in_valid;
        if (rst_n)
        begin
            if (in_valid && in_accept_cnt == in_issue_cnt)
            begin
                offer  = 1'b0;
                in_gap = $urandom_range(0, in_gap_max);
            end
            if (!offer)
            begin
                if (in_gap > 0)
                    in_gap = in_gap - 1;
                else if (sample_q.size() != 0)
                begin
                    item = sample_q.pop_front();
                    temperature_sample <= item.temp;
                    elapsed_ms         <= item.ms;
                    in_issue_cnt = in_issue_cnt + 1;
                    offer = 1'b1;
                end
            end
        end
        in_valid <= offer;
    end

    // Receiver: after each result it stalls for a random number of cycles,
    // and it holds ready low throughout the long hold-off.
    always @(negedge clk)
    begin : receiver
        if (out_accept_cnt != rx_seen)
        begin
            rx_seen = out_accept_cnt;
            rx_wait = $urandom_range(0, rx_wait_max);
        end
        if (rx_hold)
            out_ready <= 1'b0;
        else if (rx_wait > 0)
        begin
            rx_wait = rx_wait - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Long hold-off on the result side. The sender keeps offering meanwhile,
    // so the result stage fills and the block has to stall its input.
    initial
    begin : long_hold
        while (out_accept_cnt < HOLD_AFTER)
            @(posedge clk);
        rx_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold = 1'b0;
    end

    // Checks each result against the oldest expectation, then predicts the
    // result of any sample taken on this same edge.
    always @(posedge clk)
    begin : monitor
        duty_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                out_accept_cnt = out_accept_cnt + 1;
                if (expected_duty_q.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              out_accept_cnt));
                else
                begin
                    want = expected_duty_q.pop_front();
                    if (drive !== want.drive)
                        report_mismatch($sformatf("result %0d drive: got %0d, expected %0d",
                                                  out_accept_cnt, drive, want.drive));
                    if (heater_on !== want.heater_on)
                        report_mismatch($sformatf("result %0d heater_on: got %b, expected %b",
                                                  out_accept_cnt, heater_on, want.heater_on));
                    if (measured_temp !== want.temp)
                        report_mismatch($sformatf("result %0d measured_temp: got %0d, expected %0d",
                                                  out_accept_cnt, measured_temp, want.temp));
                end
            end
            if (in_valid && in_ready)
            begin
                in_accept_cnt = in_accept_cnt + 1;
                predict_duty(temperature_sample, elapsed_ms);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                       k;
        int                       n;
        int                       t;
        int                       r;
        logic signed [TEMP_W-1:0] sp;
        logic [MS_W-1:0]          ms;

        // Reset values of the registers and of the controller state.
        setpoint_r = 12'sd480;
        gain_p_r   = 16'd3840;
        gain_i_r   = '0;
        gain_d_r   = '0;
        enable_r   = 1'b0;
        integ_acc  = 0;
        prev_temp  = '0;
        prev_valid = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: the output is disabled but the integrator and the
        // last sample still move. The first sample has no derivative.
        add_sample(12'sd100, 16'd500);
        add_sample(12'sh800, 16'hFFFF);
        wait_drained();

        // Writes to indexes that decode to no register must change nothing.
        write_reg(REG_UNUSED, '1);
        write_reg(REG_TOP, '1);
        add_sample(12'sh7FF, 16'd0);
        wait_drained();

        // Moderate gains with the output enabled.
        load_settings(12'sd480, 16'd3840, 16'd4, 16'd256, 1'b1);
        add_sample(12'sd480, 16'd1000);      // zero error
        add_sample(12'sd480, 16'd0);         // zero elapsed time
        add_sample(12'sh7FF, 16'd0);         // step with no elapsed time
        add_sample(12'sh800, 16'hFFFF);      // coldest reading, longest interval
        add_sample(12'sh7FF, 16'd1);         // fastest possible rise
        add_sample(12'sh800, 16'd1);         // fastest possible fall
        add_sample(12'sd0, 16'd1000);
        add_sample(-12'sd880, 16'd250);
        add_sample(12'sd2000, 16'd250);
        add_sample(12'sd479, 16'd100);       // just below the setpoint
        add_sample(12'sd481, 16'd100);       // just above the setpoint
        add_sample(12'sd470, 16'hFFFF);
        wait_drained();

        // Full-scale gains at the highest setpoint, then the opposite extreme
        // to bring the integrator most of the way back.
        load_settings(12'sh7FF, '1, '1, '1, 1'b1);
        add_sample(12'sh800, 16'hFFFF);
        add_sample(12'sh7FF, 16'hFFFF);
        add_sample(12'sd0, 16'd1);
        wait_drained();
        load_settings(12'sh800, '0, '1, '0, 1'b1);
        add_sample(12'sh7FF, 16'hFFFF);
        wait_drained();

        // Random phases, each under its own settings. Most samples sit near
        // the setpoint so that the duty falls inside its range; the rest span
        // the whole field. One phase runs with no idling on either side.
        for (k = 0; k < PHASES; k++)
        begin
            in_gap_max  = (k == 3) ? 0 : IDLE_MAX;
            rx_wait_max = (k == 3) ? 0 : IDLE_MAX;
            case (k)
                0:       sp = 12'sh800;
                1:       sp = 12'sh7FF;
                default: sp = TEMP_W'($urandom);
            endcase
            load_settings(sp, pick_gain(4095), pick_gain(255), pick_gain(4095),
                          (k == 2) ? 1'b0 : ($urandom_range(0, 3) != 0));
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 19);
                if (r < 16)
                begin
                    t = int'(setpoint_r) + int'($urandom_range(0, 128)) - 64;
                    if (t > 2047)
                        t = 2047;
                    if (t < -2048)
                        t = -2048;
                end
                else
                    t = int'(TEMP_W'($urandom));
                r = $urandom_range(0, 9);
                if (r == 0)
                    ms = '0;
                else if (r < 3)
                    ms = MS_W'($urandom);
                else
                    ms = MS_W'($urandom_range(1, 2000));
                add_sample(TEMP_W'(t), ms);
            end
            wait_drained();
        end

        // Integrator wind-up: large errors over long intervals drive the
        // integrator into positive saturation, then all the way to negative
        // saturation. The enable is dropped for the closing stretch.
        in_gap_max  = IDLE_MAX;
        rx_wait_max = IDLE_MAX;
        load_settings(12'sh7FF, '0, '1, '0, 1'b1);
        for (n = 0; n < WINDUP_ITEMS; n++)
            add_sample(TEMP_W'(-2048 + int'($urandom_range(0, 15))),
                       MS_W'(65535 - $urandom_range(0, 15)));
        wait_drained();
        load_settings(12'sh800, 16'd64, '1, 16'd64, 1'b1);
        for (n = 0; n < WINDUP_ITEMS; n++)
            add_sample(TEMP_W'(2047 - int'($urandom_range(0, 15))),
                       MS_W'(65535 - $urandom_range(0, 15)));
        wait_drained();
        write_reg(REG_ENABLE, '0);
        for (n = 0; n < 10; n++)
            add_sample(TEMP_W'($urandom), MS_W'($urandom));

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
